@@ rtl/vpa_pkg.sv @@
// Shared types and constants for the velocity PI controller with anti-windup.
package vpa_pkg;

  localparam int unsigned MAX_COMMAND_DEF = 10000;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT  = 2'd3;

  localparam int signed CMD_MAX = 16383;
  localparam int signed CMD_MIN = -16384;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] target_speed;
    logic signed [23:0] measured_speed;
    logic        [15:0] step_time;
  } in_beat_t;

  typedef struct packed {
    logic signed [14:0] command;
    logic               fault;
    logic               limited;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integral_gain;
    logic [14:0] integral_limit;
    logic [14:0] current_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_gain;
    logic mul_inc;
    logic rnd_inc;
    logic clamp_int;
    logic mul_prop;
    logic sum_out;
    logic sat_out;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
  } dp_status_t;

endpackage

@@ rtl/vpa_cfg.sv @@
// Configuration register file for the velocity PI controller.
module vpa_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  output vpa_pkg::cfg_t                  cfg_o
);
  import vpa_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROP_GAIN:      cfg_d.prop_gain      = cfg_data_i;
        CFG_INTEGRAL_GAIN:  cfg_d.integral_gain  = cfg_data_i;
        CFG_INTEGRAL_LIMIT: cfg_d.integral_limit = cfg_data_i[14:0];
        CFG_CURRENT_LIMIT:  cfg_d.current_limit  = cfg_data_i[14:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/vpa_ctrl.sv @@
// Sequencer that steps the shared multiplier datapath through one control update.
module vpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vpa_pkg::dp_cmd_t     cmd_o,
  input  vpa_pkg::dp_status_t  status_i
);
  import vpa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULG = 4'd1;
  localparam logic [3:0] S_MULI = 4'd2;
  localparam logic [3:0] S_RNDI = 4'd3;
  localparam logic [3:0] S_CLMP = 4'd4;
  localparam logic [3:0] S_MULP = 4'd5;
  localparam logic [3:0] S_SUMU = 4'd6;
  localparam logic [3:0] S_SATU = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MULG;
        end
      end
      S_MULG: begin
        cmd_o.mul_gain = 1'b1;
        state_d        = status_i.skip ? S_DONE : S_MULI;
      end
      S_MULI: begin
        cmd_o.mul_inc = 1'b1;
        state_d       = S_RNDI;
      end
      S_RNDI: begin
        cmd_o.rnd_inc = 1'b1;
        state_d       = S_CLMP;
      end
      S_CLMP: begin
        cmd_o.clamp_int = 1'b1;
        state_d         = S_MULP;
      end
      S_MULP: begin
        cmd_o.mul_prop = 1'b1;
        state_d        = S_SUMU;
      end
      S_SUMU: begin
        cmd_o.sum_out = 1'b1;
        state_d       = S_SATU;
      end
      S_SATU: begin
        cmd_o.sat_out = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/vpa_dp.sv @@
// Datapath: shared multiplier, integrator with clamp, output saturation and rounding.
module vpa_dp #(
  parameter int unsigned MaxCommand = vpa_pkg::MAX_COMMAND_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vpa_pkg::cfg_t        cfg_i,
  input  vpa_pkg::in_beat_t    in_beat_i,
  input  vpa_pkg::dp_cmd_t     cmd_i,
  output vpa_pkg::dp_status_t  status_o,
  output vpa_pkg::out_beat_t   out_beat_o
);
  import vpa_pkg::*;

  localparam logic [14:0] MaxCmdW = 15'(MaxCommand);

  logic               kind_q;
  logic               bad_q, bad_d;
  logic signed [24:0] err_q;
  logic        [15:0] dt_q;
  logic        [31:0] gain_q;
  logic signed [57:0] prod_q;
  logic signed [38:0] inc_q, inc_d;
  logic signed [32:0] cand_q, cand_d;
  logic signed [42:0] unsat_q, unsat_d;
  logic signed [32:0] sat_q, sat_d;
  logic               lim_q, lim_d;
  logic signed [32:0] isum_q, isum_d;
  out_beat_t          out_q, out_d;

  logic               cfg_ok;
  logic signed [24:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [57:0] mul_p;

  logic        [57:0] inc_mag, inc_rsum;
  logic        [38:0] inc_r;
  logic signed [39:0] int_s, ilim;
  logic signed [42:0] clim, p_twice;
  logic               err_pos, err_neg, opposes;
  logic        [32:0] cmd_mag, cmd_rsum;
  logic        [15:0] cmd_r;
  logic signed [14:0] cmd_v;

  assign cfg_ok = ((cfg_i.prop_gain != '0) ||
                   ((cfg_i.integral_gain != '0) && (cfg_i.integral_limit != '0))) &&
                  (cfg_i.current_limit != '0) && (cfg_i.current_limit <= MaxCmdW);

  assign bad_d         = !cfg_ok || (dt_q == '0);
  assign status_o.skip = kind_q || bad_d;
  assign out_beat_o    = out_q;

  always_comb begin
    if (cmd_i.mul_gain) begin
      mul_a = {9'd0, cfg_i.integral_gain};
      mul_b = {17'd0, dt_q};
    end else if (cmd_i.mul_inc) begin
      mul_a = err_q;
      mul_b = {1'b0, gain_q};
    end else begin
      mul_a = err_q;
      mul_b = {17'd0, cfg_i.prop_gain};
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    inc_mag  = prod_q[57] ? 58'(-prod_q) : prod_q;
    inc_rsum = inc_mag + (58'd1 << 18);
    inc_r    = inc_rsum[57:19];
    inc_d    = prod_q[57] ? $signed(~inc_r + 39'd1) : $signed(inc_r);
  end

  always_comb begin
    int_s = {{7{isum_q[32]}}, isum_q} + {inc_q[38], inc_q};
    ilim  = {8'd0, cfg_i.integral_limit, 17'd0};
    if (int_s > ilim) begin
      cand_d = ilim[32:0];
    end else if (int_s < -ilim) begin
      cand_d = 33'(-ilim);
    end else begin
      cand_d = int_s[32:0];
    end
  end

  always_comb begin
    p_twice = {prod_q[40], prod_q[40:0], 1'b0};
    unsat_d = p_twice + {{10{cand_q[32]}}, cand_q};
  end

  always_comb begin
    clim = {11'd0, cfg_i.current_limit, 17'd0};
    if (unsat_q > clim) begin
      sat_d = clim[32:0];
      lim_d = 1'b1;
    end else if (unsat_q < -clim) begin
      sat_d = 33'(-clim);
      lim_d = 1'b1;
    end else begin
      sat_d = unsat_q[32:0];
      lim_d = 1'b0;
    end
    err_pos = !err_q[24] && (err_q != '0);
    err_neg = err_q[24];
    opposes = (err_pos && unsat_q < 0) || (err_neg && unsat_q > 0);
  end

  always_comb begin
    isum_d = isum_q;
    if (cmd_i.mul_gain && status_o.skip) begin
      isum_d = '0;
    end else if (cmd_i.sat_out && (!lim_d || opposes)) begin
      isum_d = cand_q;
    end
  end

  always_comb begin
    cmd_mag  = sat_q[32] ? 33'(-sat_q) : sat_q;
    cmd_rsum = cmd_mag + (33'd1 << 16);
    cmd_r    = cmd_rsum[32:17];
    if (sat_q[32]) begin
      cmd_v = (cmd_r > 16'(-CMD_MIN)) ? 15'(CMD_MIN) : $signed(15'(~cmd_r + 16'd1));
    end else begin
      cmd_v = (cmd_r > 16'(CMD_MAX)) ? 15'(CMD_MAX) : $signed(cmd_r[14:0]);
    end
    out_d = out_q;
    if (cmd_i.finish) begin
      if (kind_q || bad_q) begin
        out_d.command = '0;
        out_d.fault   = !kind_q;
        out_d.limited = 1'b0;
      end else begin
        out_d.command = cmd_v;
        out_d.fault   = 1'b0;
        out_d.limited = lim_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isum_q <= '0;
    end else begin
      isum_q <= isum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_beat_i.kind;
      err_q  <= {in_beat_i.target_speed[23], in_beat_i.target_speed} -
                {in_beat_i.measured_speed[23], in_beat_i.measured_speed};
      dt_q   <= in_beat_i.step_time;
    end
    if (cmd_i.mul_gain) begin
      bad_q  <= bad_d;
      gain_q <= mul_p[31:0];
    end
    if (cmd_i.mul_inc || cmd_i.mul_prop) begin
      prod_q <= mul_p;
    end
    if (cmd_i.rnd_inc) begin
      inc_q <= inc_d;
    end
    if (cmd_i.clamp_int) begin
      cand_q <= cand_d;
    end
    if (cmd_i.sum_out) begin
      unsat_q <= unsat_d;
    end
    if (cmd_i.sat_out) begin
      sat_q <= sat_d;
      lim_q <= lim_d;
    end
    out_q <= out_d;
  end

endmodule

@@ rtl/velocity_pi_antiwindup_unit.sv @@
// Top level of the velocity PI controller with conditional-integration anti-windup.
// Each input beat is taken only while the unit is idle. A control step runs one shared
// multiplier three times (gain times step time, that times error, then proportional
// gain times error), with rounding, clamp, sum and saturation steps; a new step
// is taken only once the last has finished. A clear request, an invalid configuration
// or a zero step time skips to the finish. The result beat sits in an output
// register, so the next input beat is taken while it waits. Configuration writes are
// always ready and must only be issued while the unit is idle.
module velocity_pi_antiwindup_unit #(
  parameter int unsigned MaxCommand = vpa_pkg::MAX_COMMAND_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  vpa_pkg::in_beat_t              in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output vpa_pkg::out_beat_t             out_beat_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import vpa_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  vpa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  vpa_dp #(
    .MaxCommand (MaxCommand)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_beat_i  (in_beat_i),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .out_beat_o (out_beat_o)
  );

endmodule
